### src/bis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types, widths and codes of the bilinear image scaler.
// ----------------------------------------------------------------------------
package bis_pkg;

	// Default geometry and precision of the block.
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_CHANNELS   = 3;
	localparam int DEF_FRAC_BITS  = 16;

	// Fixed field widths.
	localparam int COORD_W = 12;
	localparam int SRC_W   = 9;
	localparam int DST_W   = 12;
	localparam int STEP_W  = 24;
	localparam int SIZE_W  = 13;
	localparam int PROD_W  = COORD_W + STEP_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Commands.
	localparam logic CMD_WRITE   = 1'b0;
	localparam logic CMD_REQUEST = 1'b1;

	// Status codes.
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_STEP   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_STEP   = 3'd5;

	// Input item.
	typedef struct packed {
		logic               cmd;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [7:0]         chan0_in;
		logic [7:0]         chan1_in;
		logic [7:0]         chan2_in;
	} bis_in_t;

	// Result item.
	typedef struct packed {
		logic [7:0] chan0_out;
		logic [7:0] chan1_out;
		logic [7:0] chan2_out;
		logic       status;
	} bis_out_t;

endpackage

### src/bis_pix_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_pix_if
// Input channel of the scaler: pixel writes and pixel requests.
// ----------------------------------------------------------------------------
interface bis_pix_if;
	import bis_pkg::*;
	logic    valid;
	logic    ready;
	bis_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/bis_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_res_if
// Result channel of the scaler: interpolated pixels with status.
// ----------------------------------------------------------------------------
interface bis_res_if;
	import bis_pkg::*;
	logic     valid;
	logic     ready;
	bis_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/bis_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bis_cfg_if;
	import bis_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### src/bilinear_image_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_scaler
// Source pixel store with a bilinear interpolator for scaled destination pixels.
// ----------------------------------------------------------------------------
// Usage:
// The pix_in channel carries one transaction per command. A write (cmd 0)
// stores one source pixel at (row, col) in the pixel RAM in the
// cycle it is accepted and gives no result; writes outside the store are
// dropped. A request (cmd 1) names one destination pixel and gives exactly
// one res_out transaction.
// A request inside the destination size passes through the position
// multipliers, clamping, four reads of the one RAM read port for the four
// neighbors and a read-latency state, the horizontal weighting, the vertical
// weighting and the loading of the output register before res_out is valid.
// A request outside the destination size goes straight to the output load
// with status 1. The next command is taken once the result is loaded.
// The result waits in an output register; a stalled receiver holds it there
// and the block keeps accepting writes, but a new request waits for the
// register to free. The cfg channel is always ready; the user must write it
// only while the block is idle, and the block itself does not enforce this.
// Reset restores the register defaults; the pixel store is not cleared and
// must be written before it is read.
// ----------------------------------------------------------------------------
module bilinear_image_scaler
	import bis_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int CHANNELS   = DEF_CHANNELS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	bis_pix_if.sink   pix_in,
	bis_res_if.source res_out,
	bis_cfg_if.sink   cfg
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int XB    = $clog2(MAX_WIDTH);
	localparam int YB    = $clog2(MAX_HEIGHT);
	localparam int PIXW  = 8 * CHANNELS;
	localparam int IW    = PROD_W - FRAC_BITS;
	localparam int CW    = (IW > SIZE_W) ? IW : SIZE_W;
	localparam int WW    = FRAC_BITS + 1;
	localparam int TW    = 8 + FRAC_BITS + 1;
	localparam int VW    = 8 + 2 * FRAC_BITS + 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MUL   = 4'd1;
	localparam logic [3:0] S_CLAMP = 4'd2;
	localparam logic [3:0] S_RD0   = 4'd3;
	localparam logic [3:0] S_RD1   = 4'd4;
	localparam logic [3:0] S_RD2   = 4'd5;
	localparam logic [3:0] S_RD3   = 4'd6;
	localparam logic [3:0] S_RDL   = 4'd7;
	localparam logic [3:0] S_HORZ  = 4'd8;
	localparam logic [3:0] S_VERT  = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;

	localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;

	// Configuration registers.
	logic [SRC_W-1:0]  src_width_q, src_height_q;
	logic [DST_W-1:0]  dst_width_q, dst_height_q;
	logic [STEP_W-1:0] col_step_q, row_step_q;

	logic [3:0]           state_q;
	logic [COORD_W-1:0]   col_q, row_q;
	logic                 err_q;
	logic [PROD_W-1:0]    px_q, py_q;
	logic [XB-1:0]        x_q;
	logic [YB-1:0]        y_q;
	logic [FRAC_BITS-1:0] fx_q, fy_q;
	logic [PIXW-1:0]      nb_q [4];
	logic [TW-1:0]        top_q [CHANNELS];
	logic [TW-1:0]        bot_q [CHANNELS];
	logic [7:0]           chan_q [CHANNELS];
	logic                 out_valid_q;
	bis_out_t             out_data_q;

	logic            in_acc;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [PIXW-1:0] wr_data;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic [PIXW-1:0] rd_data;
	logic [SIZE_W-1:0] sw, sh, lim_x, lim_y;
	logic [CW-1:0]   xi_ext, yi_ext;
	logic [WW-1:0]   omfx, omfy;
	logic [7:0]      res_chan [3];
	logic [AW-1:0]   base_addr;

	assign cfg.ready = 1'b1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SRC_W'(256);
			src_height_q <= SRC_W'(256);
			dst_width_q  <= DST_W'(512);
			dst_height_q <= DST_W'(512);
			col_step_q   <= STEP_W'(32640);
			row_step_q   <= STEP_W'(32640);
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_SRC_WIDTH:  src_width_q  <= cfg.data[SRC_W-1:0];
				CFG_SRC_HEIGHT: src_height_q <= cfg.data[SRC_W-1:0];
				CFG_DST_WIDTH:  dst_width_q  <= cfg.data[DST_W-1:0];
				CFG_DST_HEIGHT: dst_height_q <= cfg.data[DST_W-1:0];
				CFG_COL_STEP:   col_step_q   <= cfg.data;
				CFG_ROW_STEP:   row_step_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// Input is taken when idle; a request also needs a free output register.
	assign pix_in.ready = (state_q == S_IDLE) &&
		((pix_in.data.cmd == CMD_WRITE) || !out_valid_q || res_out.ready);
	assign in_acc = pix_in.valid && pix_in.ready;

	// Pixel store write, dropped outside the store.
	assign wr_en = in_acc && (pix_in.data.cmd == CMD_WRITE) &&
		({1'b0, pix_in.data.col} < SIZE_W'(MAX_WIDTH)) &&
		({1'b0, pix_in.data.row} < SIZE_W'(MAX_HEIGHT));
	assign wr_addr = AW'(pix_in.data.row) * AW'(MAX_WIDTH) + AW'(pix_in.data.col);
	assign wr_data = PIXW'({pix_in.data.chan2_in, pix_in.data.chan1_in,
		pix_in.data.chan0_in});

	// Neighbor read addresses, one per read state.
	assign base_addr = AW'(y_q) * AW'(MAX_WIDTH) + AW'(x_q);
	always_comb begin
		rd_en   = 1'b1;
		rd_addr = base_addr;
		case (state_q)
			S_RD0: rd_addr = base_addr;
			S_RD1: rd_addr = base_addr + AW'(1);
			S_RD2: rd_addr = base_addr + AW'(MAX_WIDTH);
			S_RD3: rd_addr = base_addr + AW'(MAX_WIDTH) + AW'(1);
			default: rd_en = 1'b0;
		endcase
	end

	bis_ram #(.WIDTH(PIXW), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Source sizes clamped to at least 2 and at most the store, and the last valid base index.
	always_comb begin
		if (src_width_q < SRC_W'(2)) sw = SIZE_W'(2);
		else if (SIZE_W'(src_width_q) > SIZE_W'(MAX_WIDTH)) sw = SIZE_W'(MAX_WIDTH);
		else sw = SIZE_W'(src_width_q);
		if (src_height_q < SRC_W'(2)) sh = SIZE_W'(2);
		else if (SIZE_W'(src_height_q) > SIZE_W'(MAX_HEIGHT)) sh = SIZE_W'(MAX_HEIGHT);
		else sh = SIZE_W'(src_height_q);
		lim_x  = sw - SIZE_W'(2);
		lim_y  = sh - SIZE_W'(2);
		xi_ext = CW'(px_q[PROD_W-1:FRAC_BITS]);
		yi_ext = CW'(py_q[PROD_W-1:FRAC_BITS]);
		omfx   = ONE - WW'(fx_q);
		omfy   = ONE - WW'(fy_q);
	end

	// Request sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:  if (in_acc && pix_in.data.cmd == CMD_REQUEST) begin
					state_q <= ((pix_in.data.col >= dst_width_q) ||
						(pix_in.data.row >= dst_height_q)) ? S_OUT : S_MUL;
				end
				S_MUL:   state_q <= S_CLAMP;
				S_CLAMP: state_q <= S_RD0;
				S_RD0:   state_q <= S_RD1;
				S_RD1:   state_q <= S_RD2;
				S_RD2:   state_q <= S_RD3;
				S_RD3:   state_q <= S_RDL;
				S_RDL:   state_q <= S_HORZ;
				S_HORZ:  state_q <= S_VERT;
				S_VERT:  state_q <= S_OUT;
				S_OUT:   if (!out_valid_q || res_out.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Position, clamping and neighbor capture.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			col_q <= pix_in.data.col;
			row_q <= pix_in.data.row;
			err_q <= (pix_in.data.col >= dst_width_q) || (pix_in.data.row >= dst_height_q);
		end
		if (state_q == S_MUL) begin
			px_q <= PROD_W'(col_q) * PROD_W'(col_step_q);
			py_q <= PROD_W'(row_q) * PROD_W'(row_step_q);
		end
		if (state_q == S_CLAMP) begin
			x_q  <= XB'((xi_ext > CW'(lim_x)) ? CW'(lim_x) : xi_ext);
			y_q  <= YB'((yi_ext > CW'(lim_y)) ? CW'(lim_y) : yi_ext);
			fx_q <= px_q[FRAC_BITS-1:0];
			fy_q <= py_q[FRAC_BITS-1:0];
		end
		if (state_q == S_RD1) nb_q[0] <= rd_data;
		if (state_q == S_RD2) nb_q[1] <= rd_data;
		if (state_q == S_RD3) nb_q[2] <= rd_data;
		if (state_q == S_RDL) nb_q[3] <= rd_data;
	end

	// Per-channel weighting lanes: horizontal, then vertical.
	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		always_ff @(posedge clk) begin
			if (state_q == S_HORZ) begin
				top_q[c] <= TW'(nb_q[0][8*c +: 8]) * TW'(omfx) +
					TW'(nb_q[1][8*c +: 8]) * TW'(fx_q);
				bot_q[c] <= TW'(nb_q[2][8*c +: 8]) * TW'(omfx) +
					TW'(nb_q[3][8*c +: 8]) * TW'(fx_q);
			end
			if (state_q == S_VERT) begin
				chan_q[c] <= 8'((VW'(top_q[c]) * VW'(omfy) +
					VW'(bot_q[c]) * VW'(fy_q)) >> (2 * FRAC_BITS));
			end
		end
	end

	// Unused channels read as zero, as do all channels of a range error.
	for (genvar c = 0; c < 3; c++) begin : g_res
		if (c < CHANNELS) begin : g_used
			assign res_chan[c] = err_q ? 8'd0 : chan_q[c];
		end else begin : g_unused
			assign res_chan[c] = 8'd0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && (!out_valid_q || res_out.ready)) begin
			out_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid_q || res_out.ready)) begin
			out_data_q.chan0_out <= res_chan[0];
			out_data_q.chan1_out <= res_chan[1];
			out_data_q.chan2_out <= res_chan[2];
			out_data_q.status    <= err_q ? STATUS_RANGE : STATUS_OK;
		end
	end

	assign res_out.valid = out_valid_q;
	assign res_out.data  = out_data_q;

	// Store writes happen only between requests.
	a_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == S_IDLE)
		else $error("pixel write outside idle");

	// A new result follows only the output-load state.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result without load state");

	// The clamped base keeps all four neighbors inside the source image.
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD0 |-> (SIZE_W'(x_q) <= lim_x) && (SIZE_W'(y_q) <= lim_y))
		else $error("neighbor base beyond image");

	// An accepted request leaves idle in the next cycle.
	a_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && pix_in.data.cmd == CMD_REQUEST |=> state_q == S_MUL || state_q == S_OUT)
		else $error("request not started");

endmodule

### src/bis_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bis_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
